[rtl/core/pxnd_pkg.sv]
// Package: shared types, widths and codes for the pairwise XOR network decoder
`timescale 1ns / 1ps
`default_nettype none
package pxnd_pkg;

    localparam int ID_W      = 8;
    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 9;
    localparam int EVENT_W   = 2;

    localparam logic [COUNT_W-1:0] NUM_PACKETS_RESET = 9'd256;

    typedef enum logic [EVENT_W-1:0] {
        EV_IGNORED  = 2'd0,
        EV_ORIGINAL = 2'd1,
        EV_DECODED  = 2'd2
    } t_event;

    typedef struct packed {
        logic load;
        logic check;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

[rtl/core/pxnd_if.sv]
// Interfaces: symbol, result and configuration channels
`timescale 1ns / 1ps
`default_nettype none
interface pxnd_sym_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [pxnd_pkg::ID_W-1:0]  id_first;
    logic [pxnd_pkg::ID_W-1:0]  id_second;
    logic [pxnd_pkg::WORD_W-1:0] payload;

    modport source (output valid, mode, id_first, id_second, payload, input ready);
    modport sink (input valid, mode, id_first, id_second, payload, output ready);
endinterface

interface pxnd_res_if;
    logic                          valid;
    logic                          ready;
    logic [pxnd_pkg::EVENT_W-1:0]  event_res;
    logic [pxnd_pkg::ID_W-1:0]     packet_id;
    logic [pxnd_pkg::WORD_W-1:0]   packet_data;
    logic [pxnd_pkg::COUNT_W-1:0]  received_total;

    modport source (output valid, event_res, packet_id, packet_data, received_total,
                    input ready);
    modport sink (input valid, event_res, packet_id, packet_data, received_total,
                  output ready);
endinterface

interface pxnd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pxnd_pkg::COUNT_W-1:0]  num_packets;

    modport source (output valid, num_packets, input ready);
    modport sink (input valid, num_packets, output ready);
endinterface
`default_nettype wire

[rtl/core/pxnd_ctrl.sv]
// Controller: sequences load, lookup and commit of one item
`timescale 1ns / 1ps
`default_nettype none
module pxnd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pxnd_pkg::t_status i_status,
    output pxnd_pkg::t_cmd         o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.check   = (r_state == S_CHECK);
    assign o_cmd.commit  = (r_state == S_FINISH) && !i_status.out_busy;

endmodule
`default_nettype wire

[rtl/core/pxnd_datapath.sv]
// Datapath: have-packet bitmap, payload store, held count and result register
`timescale 1ns / 1ps
`default_nettype none
module pxnd_datapath #(
    parameter int MAX_PACKETS  = 256,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pxnd_pkg::t_cmd                    i_cmd,
    output pxnd_pkg::t_status                      o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [pxnd_pkg::COUNT_W-1:0]      i_cfg_num_packets,
    input  wire logic                              i_mode,
    input  wire logic [pxnd_pkg::ID_W-1:0]         i_id_first,
    input  wire logic [pxnd_pkg::ID_W-1:0]         i_id_second,
    input  wire logic [pxnd_pkg::WORD_W-1:0]       i_payload,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [pxnd_pkg::EVENT_W-1:0]           o_event_res,
    output logic [pxnd_pkg::ID_W-1:0]              o_packet_id,
    output logic [pxnd_pkg::WORD_W-1:0]            o_packet_data,
    output logic [pxnd_pkg::COUNT_W-1:0]           o_received_total
);

    localparam int ID_SPAN = 1 << pxnd_pkg::ID_W;
    localparam int DEPTH   = (MAX_PACKETS < ID_SPAN) ? MAX_PACKETS : ID_SPAN;
    localparam int AW      = $clog2(DEPTH);

    logic [pxnd_pkg::COUNT_W-1:0]  r_num_packets;
    logic [DEPTH-1:0]              r_have;
    logic [pxnd_pkg::COUNT_W-1:0]  r_count;

    logic                          r_mode;
    logic [pxnd_pkg::ID_W-1:0]     r_a;
    logic [pxnd_pkg::ID_W-1:0]     r_b;
    logic [PAYLOAD_BITS-1:0]       r_word;

    pxnd_pkg::t_event              r_ev;
    logic [AW-1:0]                 r_miss;
    logic [PAYLOAD_BITS-1:0]       r_rd_data;
    logic [PAYLOAD_BITS-1:0]       r_store [DEPTH];

    logic                          r_out_valid;
    pxnd_pkg::t_event              r_out_ev;
    logic [pxnd_pkg::ID_W-1:0]     r_out_id;
    logic [pxnd_pkg::WORD_W-1:0]   r_out_data;
    logic [pxnd_pkg::COUNT_W-1:0]  r_out_total;

    logic                          ok_a;
    logic                          ok_b;
    logic                          have_a;
    logic                          have_b;
    logic [AW-1:0]                 idx_a;
    logic [AW-1:0]                 idx_b;
    pxnd_pkg::t_event              n_ev;
    logic [AW-1:0]                 n_miss;
    logic [AW-1:0]                 known;
    logic [PAYLOAD_BITS-1:0]       new_data;
    logic                          store_en;
    logic [pxnd_pkg::COUNT_W-1:0]  n_count;

    assign idx_a  = r_a[AW-1:0];
    assign idx_b  = r_b[AW-1:0];
    assign ok_a   = ({1'b0, r_a} < r_num_packets) && (32'(r_a) < DEPTH);
    assign ok_b   = ({1'b0, r_b} < r_num_packets) && (32'(r_b) < DEPTH);
    assign have_a = ok_a && r_have[idx_a];
    assign have_b = ok_b && r_have[idx_b];

    always_comb begin
        n_ev   = pxnd_pkg::EV_IGNORED;
        n_miss = idx_a;
        known  = idx_b;
        if (!r_mode) begin
            if (ok_a && !have_a) begin
                n_ev = pxnd_pkg::EV_ORIGINAL;
            end
        end else if (ok_a && ok_b && (have_a != have_b)) begin
            n_ev = pxnd_pkg::EV_DECODED;
            if (have_a) begin
                n_miss = idx_b;
                known  = idx_a;
            end
        end
    end

    assign new_data = (r_ev == pxnd_pkg::EV_DECODED) ? (r_word ^ r_rd_data) : r_word;
    assign store_en = i_cmd.commit && (r_ev != pxnd_pkg::EV_IGNORED);
    assign n_count  = store_en ? (r_count + pxnd_pkg::COUNT_W'(1)) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_packets <= pxnd_pkg::NUM_PACKETS_RESET;
            r_have        <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_packets <= i_cfg_num_packets;
            end
            if (store_en) begin
                r_have[r_miss] <= 1'b1;
            end
            r_count <= n_count;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_a    <= i_id_first;
            r_b    <= i_id_second;
            r_word <= i_payload[PAYLOAD_BITS-1:0];
        end
        if (i_cmd.check) begin
            r_ev      <= n_ev;
            r_miss    <= n_miss;
            r_rd_data <= r_store[known];
        end
        if (store_en) begin
            r_store[r_miss] <= new_data;
        end
        if (i_cmd.commit) begin
            r_out_ev    <= r_ev;
            r_out_total <= n_count;
            if (r_ev == pxnd_pkg::EV_IGNORED) begin
                r_out_id   <= '0;
                r_out_data <= '0;
            end else begin
                r_out_id   <= pxnd_pkg::ID_W'(r_miss);
                r_out_data <= pxnd_pkg::WORD_W'(new_data);
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_event_res       = r_out_ev;
    assign o_packet_id       = r_out_id;
    assign o_packet_data     = r_out_data;
    assign o_received_total  = r_out_total;

endmodule
`default_nettype wire

[rtl/core/pairwise_xor_network_decoder.sv]
// Top level: pairwise XOR network decoder with symbol, result and config channels
//
// Usage:
//   i_sym carries one symbol per item: an original packet (mode 0) or the XOR
//   of two packets (mode 1). o_res returns exactly one result item per symbol:
//   the event code, the id and payload of the packet stored or recovered, and
//   the number of packets held afterwards. i_cfg writes num_packets; write it
//   only while no symbol is in flight. It is always ready.
//   A symbol is taken only while the decoder is idle; it is then loaded, checked
//   against the bitmap with a read of the single payload store, and committed
//   with the write-back of the stored packet before the next symbol is taken.
//   Reset clears the have-packet bitmap and the held count and sets num_packets
//   to 256; the payload store is not cleared, and only held entries are used.
//   A stalled receiver holds the result register; the next symbol is still
//   accepted and waits in its final step until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_xor_network_decoder #(
    parameter int MAX_PACKETS  = 256,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    pxnd_sym_if.sink      i_sym,
    pxnd_res_if.source    o_res,
    pxnd_cfg_if.sink      i_cfg
);

    pxnd_pkg::t_cmd    cmd;
    pxnd_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    pxnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sym.valid),
        .o_in_ready (i_sym.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pxnd_datapath #(
        .MAX_PACKETS  (MAX_PACKETS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_num_packets (i_cfg.num_packets),
        .i_mode            (i_sym.mode),
        .i_id_first        (i_sym.id_first),
        .i_id_second       (i_sym.id_second),
        .i_payload         (i_sym.payload),
        .o_out_valid       (o_res.valid),
        .i_out_ready       (o_res.ready),
        .o_event_res       (o_res.event_res),
        .o_packet_id       (o_res.packet_id),
        .o_packet_data     (o_res.packet_data),
        .o_received_total  (o_res.received_total)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_res.valid && !o_res.ready))
        else $error("result overwritten while stalled");

    a_accept_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sym.valid && i_sym.ready) |=> (cmd.check && !i_sym.ready))
        else $error("accepted item not checked next cycle");

    a_commit_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_res.valid)
        else $error("commit without result");

    a_ignored_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.event_res == pxnd_pkg::EV_IGNORED))
            |-> ((o_res.packet_id == '0) && (o_res.packet_data == '0)))
        else $error("ignored result carries data");

endmodule
`default_nettype wire

[bench/pxnd_recovery_check.sv]
// Observer for the pairwise XOR network decoder: predicts and compares every result item
`timescale 1ns / 1ps
module pxnd_recovery_check (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pxnd_sym_if       i_sym,
    pxnd_res_if       i_res,
    pxnd_cfg_if       i_cfg,
    output int        o_pending,
    output int        o_errors
);

    typedef struct packed {
        pxnd_pkg::t_event                ev;
        logic [pxnd_pkg::ID_W-1:0]       id;
        logic [pxnd_pkg::WORD_W-1:0]     data;
        logic [pxnd_pkg::COUNT_W-1:0]    total;
    } t_outcome;

    logic                            have_map [256];
    logic [pxnd_pkg::WORD_W-1:0]     packet_words [256];
    logic [pxnd_pkg::COUNT_W-1:0]    held_total;
    logic [pxnd_pkg::COUNT_W-1:0]    gen_size;
    t_outcome                        due_outcomes [$];
    t_outcome                        want;
    int                              fail_count = 0;

    function automatic logic in_gen(input logic [pxnd_pkg::ID_W-1:0] id);
        return {1'b0, id} < gen_size;
    endfunction

    function automatic t_outcome decode_symbol(
        input logic                          is_pair,
        input logic [pxnd_pkg::ID_W-1:0]     a,
        input logic [pxnd_pkg::ID_W-1:0]     b,
        input logic [pxnd_pkg::WORD_W-1:0]   word
    );
        t_outcome                    r;
        logic [pxnd_pkg::ID_W-1:0]   miss;
        logic [pxnd_pkg::ID_W-1:0]   known;
        r.ev   = pxnd_pkg::EV_IGNORED;
        r.id   = '0;
        r.data = '0;
        if (!is_pair) begin
            if (in_gen(a) && !have_map[a]) begin
                have_map[a]     = 1'b1;
                packet_words[a] = word;
                held_total      = held_total + pxnd_pkg::COUNT_W'(1);
                r.ev   = pxnd_pkg::EV_ORIGINAL;
                r.id   = a;
                r.data = word;
            end
        end else if (in_gen(a) && in_gen(b) && (have_map[a] != have_map[b])) begin
            miss  = have_map[a] ? b : a;
            known = have_map[a] ? a : b;
            r.data = word ^ packet_words[known];
            have_map[miss]     = 1'b1;
            packet_words[miss] = r.data;
            held_total         = held_total + pxnd_pkg::COUNT_W'(1);
            r.ev = pxnd_pkg::EV_DECODED;
            r.id = miss;
        end
        r.total = held_total;
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [pxnd_pkg::WORD_W-1:0] want_v,
                              input logic [pxnd_pkg::WORD_W-1:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, field, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (have_map[k]) have_map[k] = 1'b0;
            held_total = '0;
            gen_size   = pxnd_pkg::NUM_PACKETS_RESET;
            due_outcomes.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) gen_size = i_cfg.num_packets;
            if (i_sym.valid && i_sym.ready)
                due_outcomes.push_back(decode_symbol(i_sym.mode, i_sym.id_first,
                                                     i_sym.id_second, i_sym.payload));
            if (i_res.valid && i_res.ready) begin
                if (due_outcomes.size() == 0) begin
                    fail_count++;
                    $display({"%0t: result item with nothing outstanding: expected none, ",
                              "actual event %0d id %0d data %0h total %0d"},
                             $time, i_res.event_res, i_res.packet_id, i_res.packet_data,
                             i_res.received_total);
                end else begin
                    want = due_outcomes.pop_front();
                    flag_field("event_res", pxnd_pkg::WORD_W'(want.ev),
                               pxnd_pkg::WORD_W'(i_res.event_res));
                    flag_field("packet_id", pxnd_pkg::WORD_W'(want.id),
                               pxnd_pkg::WORD_W'(i_res.packet_id));
                    flag_field("packet_data", want.data, i_res.packet_data);
                    flag_field("received_total", pxnd_pkg::WORD_W'(want.total),
                               pxnd_pkg::WORD_W'(i_res.received_total));
                end
            end
        end
        o_pending <= due_outcomes.size();
        o_errors  <= fail_count;
    end

endmodule

[bench/testbench.sv]
// Testbench top: clock, reset, symbol and configuration stimulus, result back-pressure, verdict
`timescale 1ns / 1ps
module testbench;

    localparam logic MODE_ORIGINAL = 1'b0;
    localparam logic MODE_PAIR     = 1'b1;
    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   HOLD_CYCLES   = 120;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_total;
    int   cycle_count = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   long_hold_req = 1'b0;
    bit   hold_done = 1'b0;

    pxnd_sym_if sym_ch ();
    pxnd_res_if res_ch ();
    pxnd_cfg_if cfg_ch ();

    pairwise_xor_network_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    pxnd_recovery_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sym     (sym_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_pending (pending),
        .o_errors  (fail_total)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_symbol(input logic mode, input logic [pxnd_pkg::ID_W-1:0] a,
                               input logic [pxnd_pkg::ID_W-1:0] b,
                               input logic [pxnd_pkg::WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            sym_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sym_ch.valid     <= 1'b1;
        sym_ch.mode      <= mode;
        sym_ch.id_first  <= a;
        sym_ch.id_second <= b;
        sym_ch.payload   <= word;
        @(posedge i_clk);
        while (!sym_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_gen_size(input logic [pxnd_pkg::COUNT_W-1:0] size);
        sym_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.num_packets <= size;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [pxnd_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic random_symbol(input int gen);
        int roll;
        int top_id;
        roll   = $urandom_range(99);
        top_id = ((gen > 256) ? 256 : gen) - 1;
        if (roll < 10)
            send_symbol(1'($urandom_range(1)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), rand_word());
        else if (roll < 45)
            send_symbol(MODE_ORIGINAL, 8'($urandom_range(top_id)),
                        8'($urandom_range(255)), rand_word());
        else
            send_symbol(MODE_PAIR, 8'($urandom_range(top_id)),
                        8'($urandom_range(top_id)), rand_word());
    endtask

    initial begin
        int ph;
        int gen;
        sym_ch.valid       <= 1'b0;
        sym_ch.mode        <= MODE_ORIGINAL;
        sym_ch.id_first    <= '0;
        sym_ch.id_second   <= '0;
        sym_ch.payload     <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.num_packets <= pxnd_pkg::NUM_PACKETS_RESET;
        i_rst_n            <= 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 59;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_symbol(MODE_ORIGINAL, 8'd0, 8'd0, '1);
        send_symbol(MODE_ORIGINAL, 8'd255, 8'hFF, '0);
        send_symbol(MODE_ORIGINAL, 8'd0, 8'd0, rand_word());
        send_symbol(MODE_PAIR, 8'd0, 8'd1, rand_word());
        send_symbol(MODE_PAIR, 8'd254, 8'd255, rand_word());
        send_symbol(MODE_PAIR, 8'd1, 8'd0, rand_word());
        send_symbol(MODE_PAIR, 8'd2, 8'd3, rand_word());
        send_symbol(MODE_PAIR, 8'd0, 8'd0, rand_word());
        send_symbol(MODE_PAIR, 8'd4, 8'd4, rand_word());
        write_gen_size(9'd0);
        send_symbol(MODE_ORIGINAL, 8'd5, 8'd0, rand_word());
        send_symbol(MODE_PAIR, 8'd0, 8'd6, rand_word());
        write_gen_size(9'd1);
        send_symbol(MODE_ORIGINAL, 8'd7, 8'd0, rand_word());
        send_symbol(MODE_PAIR, 8'd0, 8'd8, rand_word());
        write_gen_size(9'd10);
        send_symbol(MODE_ORIGINAL, 8'd9, 8'd0, rand_word());
        send_symbol(MODE_ORIGINAL, 8'd10, 8'd0, rand_word());
        send_symbol(MODE_PAIR, 8'd9, 8'd10, rand_word());
        send_symbol(MODE_PAIR, 8'd9, 8'd8, rand_word());
        write_gen_size(9'd511);
        send_symbol(MODE_PAIR, 8'd255, 8'd200, rand_word());
        send_symbol(MODE_ORIGINAL, 8'd128, 8'd0, rand_word());

        for (ph = 0; ph < 8; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 26;
                recv_idle_pct = 59;
            end else if (ph < 6) begin
                send_idle_pct = 59;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            gen = (ph == 7) ? 256 : 32 * (ph + 1);
            write_gen_size(pxnd_pkg::COUNT_W'(gen));
            if (ph == 1) long_hold_req = 1'b1;
            repeat (200) random_symbol(gen);
        end

        sym_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_total == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
